@@ rtl/fpc_pkg.sv @@
// Shared types and constants for the first-person camera update block.
package fpc_pkg;

    localparam int IN_W       = 152;
    localparam int OUT_W      = 184;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUSE_ENABLED = 2'd0,
        CFG_MOUSE_GAIN    = 2'd1,
        CFG_MOVE_SPEED    = 2'd2
    } t_cfg_idx;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    // angle in degrees Q.8, wide enough for yaw plus any step offset
    typedef logic signed [18:0] t_ang;
    // turn arithmetic before wrap and clamp
    typedef logic signed [21:0] t_turn;

    localparam t_ang ANG_90  = 19'sd23040;
    localparam t_ang ANG_180 = 19'sd46080;
    localparam t_ang ANG_270 = 19'sd69120;
    localparam t_ang ANG_360 = 19'sd92160;
    localparam t_ang ANG_720 = 19'sd184320;

    localparam t_turn TURN_90  = 22'sd23040;
    localparam t_turn TURN_360 = 22'sd92160;

    localparam logic signed [11:0] MID_X = 12'sd320;
    localparam logic signed [11:0] MID_Y = 12'sd240;

    // shared multiply-add operands
    typedef logic signed [19:0] t_mop;
    typedef logic signed [39:0] t_macc;

    typedef struct packed {
        t_mop  a;
        t_mop  b;
        t_macc c;
    } t_mac_op;

    // floor(v/45) = (v*RECIP_45) >> 24 for v below 2^18
    localparam t_mop RECIP_45 = 20'sd372828;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TURN_Y,
        ST_TURN_P,
        ST_TURN_FIX,
        ST_MOVE_SEL,
        ST_SIN_RED,
        ST_SIN_QUAD,
        ST_SIN_MUL1,
        ST_SIN_MUL2,
        ST_SIN_ADDR,
        ST_SIN_DATA,
        ST_MOVE_MX,
        ST_MOVE_MZ,
        ST_MOVE_UPD,
        ST_VIEW,
        ST_VIEW_MX,
        ST_VIEW_MZ,
        ST_VIEW_VZ,
        ST_DONE
    } t_state;

endpackage

@@ rtl/fpc_mac.sv @@
// Shared signed multiply-add unit with registered result.
module fpc_mac (
    input  logic             i_clk,
    input  fpc_pkg::t_mac_op i_op,
    output fpc_pkg::t_macc   o_p
);
    import fpc_pkg::*;

    t_macc r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_op.a * i_op.b + i_op.c;
    end

    assign o_p = r_p;

endmodule

@@ rtl/fpc_sine.sv @@
// Quarter-wave sine table in unsigned Q1.14, built at elaboration, registered read.
module fpc_sine #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH+1)-1:0] i_addr,
    output logic [14:0]                o_data
);
    import fpc_pkg::*;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    logic [14:0] w_tab [DEPTH+1];
    logic [14:0] r_data;

    // Taylor series in Q30, terms up to x^11
    for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_tab
        localparam logic [63:0] X    = 64'(gi) * PI_Q30 / 64'(2 * DEPTH);
        localparam logic [63:0] X2   = (X * X) >> 30;
        localparam logic [63:0] T1   = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2   = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3   = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4   = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5   = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] SUM  = X - T1 + T2 - T3 + T4 - T5;
        localparam logic [63:0] POS  = SUM[63] ? 64'd0 : SUM;
        localparam logic [63:0] RND  = (POS + 64'd32768) >> 16;
        localparam logic [63:0] CAP  = (RND > 64'd16384) ? 64'd16384 : RND;
        assign w_tab[gi] = CAP[14:0];
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ rtl/first_person_camera_update_top.sv @@
// First-person camera update: yaw/pitch mouse look, key movement, view vector.
// A place or a disabled tick goes straight to the view vector; an enabled tick first runs
// turn and key decode, then a movement step for each pressed pair: keys 0/1, then keys 2/3.
// Throughput: one request at a time, next accepted in the cycle after the result loads.
// Each sine uses the shared multiply-add unit and the table read port.
// Reset (synchronous, active low) zeroes position and angles, loads config defaults.
module first_person_camera_update_top #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // mouse_x, mouse_y, key_mask, set_x, set_y, set_z, set_yaw, set_pitch
    input  logic [fpc_pkg::IN_W-1:0]        i_s_tdata,
    // kind
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pos_x, pos_y, pos_z, yaw_out, pitch_out, view_x, view_y, view_z, zero pad
    output logic [fpc_pkg::OUT_W-1:0]       o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fpc_pkg::*;

    localparam int          IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam t_mop        TWO_D = t_mop'(2 * SINE_TABLE_DEPTH);
    localparam logic [13:0] D14   = 14'(SINE_TABLE_DEPTH);

    function automatic logic [16:0] mod360(input t_ang a);
        t_ang m;
        if (a < 0)
            m = a + ANG_360;
        else if (a < ANG_360)
            m = a;
        else if (a < ANG_720)
            m = a - ANG_360;
        else
            m = a - ANG_720;
        return m[16:0];
    endfunction

    function automatic logic [16:0] yaw_fix(input t_turn y);
        t_turn v;
        v = y;
        if (v < 0)
            v = v + TURN_360;
        if (v > TURN_360)
            v = v - TURN_360;
        if (v < 0)
            v = '0;
        if (v > TURN_360)
            v = TURN_360;
        return v[16:0];
    endfunction

    function automatic logic signed [15:0] pitch_fix(input t_turn p);
        t_turn v;
        v = p;
        if (v > TURN_90)
            v = TURN_90;
        if (v < -TURN_90)
            v = -TURN_90;
        return v[15:0];
    endfunction

    t_state r_state, n_state;

    logic               r_en;
    logic [12:0]        r_gain;
    logic [15:0]        r_speed;
    logic [31:0]        r_px, r_py, r_pz;
    logic [16:0]        r_yaw;
    logic signed [15:0] r_pitch;

    logic [9:0]         r_mx;
    logic [8:0]         r_my;
    logic [3:0]         r_keys;
    t_turn              r_ynew;
    logic               r_mv;
    logic               r_view;
    logic [1:0]         r_sel;
    t_ang               r_ang;
    logic [16:0]        r_m;
    logic [1:0]         r_q;
    logic [14:0]        r_r;
    logic signed [15:0] r_sv [4];
    logic signed [15:0] r_vx, r_vz;

    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;

    t_mac_op            w_op;
    t_macc              w_p;
    t_macc              w_sh4, w_sh10, w_neg14;
    logic [IW-1:0]      w_addr;
    logic [14:0]        w_rom;
    logic signed [11:0] w_offx, w_offy;
    t_turn              w_turn_y, w_turn_p;
    logic               w_act;
    t_ang               w_dir, w_move_ang;
    logic [13:0]        w_idx_raw, w_idx_clip, w_idx;
    logic signed [15:0] w_mag, w_sval;
    logic               w_accept, w_out_load;

    fpc_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_p   (w_p)
    );

    fpc_sine #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_rom)
    );

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == ST_DONE) && (!r_ovalid || i_m_tready);

    assign w_offx   = MID_X - $signed({2'b0, r_mx});
    assign w_offy   = MID_Y - $signed({3'b0, r_my});
    assign w_sh4    = w_p >>> 4;
    assign w_sh10   = w_p >>> 10;
    assign w_neg14  = -(w_p >>> 14);
    assign w_turn_y = t_turn'({1'b0, r_yaw}) + t_turn'(w_sh4);
    assign w_turn_p = t_turn'(r_pitch) + t_turn'(w_sh4);

    always_comb begin
        if (!r_mv) begin
            w_act = r_keys[0] || r_keys[1];
            w_dir = r_keys[0] ? '0 : ANG_180;
        end else begin
            w_act = r_keys[2] || r_keys[3];
            w_dir = r_keys[2] ? ANG_90 : ANG_270;
        end
    end
    assign w_move_ang = t_ang'({2'b0, r_yaw}) + w_dir;

    // table index: round(r*D/90deg), folded for odd quadrants
    assign w_idx_raw  = {1'b0, w_p[36:24]};
    assign w_idx_clip = (w_idx_raw > D14) ? D14 : w_idx_raw;
    assign w_idx      = r_q[0] ? (D14 - w_idx_clip) : w_idx_clip;
    assign w_addr     = w_idx[IW-1:0];

    assign w_mag  = $signed({1'b0, w_rom});
    assign w_sval = r_q[1] ? -w_mag : w_mag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == KIND_TICK && r_en)
                        n_state = ST_TURN_Y;
                    else
                        n_state = ST_VIEW;
                end
            end
            ST_TURN_Y:   n_state = ST_TURN_P;
            ST_TURN_P:   n_state = ST_TURN_FIX;
            ST_TURN_FIX: n_state = ST_MOVE_SEL;
            ST_MOVE_SEL: begin
                if (w_act)
                    n_state = ST_SIN_RED;
                else if (r_mv)
                    n_state = ST_VIEW;
            end
            ST_SIN_RED:  n_state = ST_SIN_QUAD;
            ST_SIN_QUAD: n_state = ST_SIN_MUL1;
            ST_SIN_MUL1: n_state = ST_SIN_MUL2;
            ST_SIN_MUL2: n_state = ST_SIN_ADDR;
            ST_SIN_ADDR: n_state = ST_SIN_DATA;
            ST_SIN_DATA: begin
                if (r_view)
                    n_state = (r_sel == 2'd3) ? ST_VIEW_MX : ST_SIN_RED;
                else
                    n_state = (r_sel == 2'd1) ? ST_MOVE_MX : ST_SIN_RED;
            end
            ST_MOVE_MX:  n_state = ST_MOVE_MZ;
            ST_MOVE_MZ:  n_state = ST_MOVE_UPD;
            ST_MOVE_UPD: n_state = r_mv ? ST_VIEW : ST_MOVE_SEL;
            ST_VIEW:     n_state = ST_SIN_RED;
            ST_VIEW_MX:  n_state = ST_VIEW_MZ;
            ST_VIEW_MZ:  n_state = ST_VIEW_VZ;
            ST_VIEW_VZ:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load)
                    n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_op       = '0;
        case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_TURN_Y: begin
                w_op.a = t_mop'({7'b0, r_gain});
                w_op.b = t_mop'(w_offx);
                w_op.c = 40'sd8;
            end
            ST_TURN_P: begin
                w_op.a = t_mop'({7'b0, r_gain});
                w_op.b = t_mop'(w_offy);
                w_op.c = 40'sd8;
            end
            ST_SIN_MUL1: begin
                w_op.a = t_mop'({5'b0, r_r});
                w_op.b = TWO_D;
                w_op.c = 40'sd23040;
            end
            ST_SIN_MUL2: begin
                w_op.a = t_mop'({2'b0, w_p[27:10]});
                w_op.b = RECIP_45;
            end
            ST_MOVE_MX: begin
                w_op.a = t_mop'(r_sv[0]);
                w_op.b = t_mop'({4'b0, r_speed});
                w_op.c = 40'sd512;
            end
            ST_MOVE_MZ: begin
                w_op.a = t_mop'(r_sv[1]);
                w_op.b = t_mop'({4'b0, r_speed});
                w_op.c = 40'sd512;
            end
            ST_VIEW_MX: begin
                w_op.a = t_mop'(r_sv[3]);
                w_op.b = t_mop'(r_sv[0]);
                w_op.c = 40'sd8192;
            end
            ST_VIEW_MZ: begin
                w_op.a = t_mop'(r_sv[3]);
                w_op.b = t_mop'(r_sv[1]);
                w_op.c = 40'sd8192;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_en     <= 1'b0;
            r_gain   <= 13'd205;
            r_speed  <= 16'd819;
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_yaw    <= '0;
            r_pitch  <= '0;
            r_mv     <= 1'b0;
            r_view   <= 1'b0;
            r_sel    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MOUSE_ENABLED: r_en    <= i_cfg_data[0];
                    CFG_MOUSE_GAIN:    r_gain  <= i_cfg_data[12:0];
                    CFG_MOVE_SPEED:    r_speed <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (w_out_load)
                r_ovalid <= 1'b1;
            else if (i_m_tready)
                r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_s_tuser == KIND_PLACE) begin
                        r_px    <= i_s_tdata[54:23];
                        r_py    <= i_s_tdata[86:55];
                        r_pz    <= i_s_tdata[118:87];
                        r_yaw   <= i_s_tdata[135:119];
                        r_pitch <= i_s_tdata[151:136];
                    end
                end
                ST_TURN_FIX: begin
                    r_yaw   <= yaw_fix(r_ynew);
                    r_pitch <= pitch_fix(w_turn_p);
                    r_mv    <= 1'b0;
                end
                ST_MOVE_SEL: begin
                    if (w_act) begin
                        r_view <= 1'b0;
                        r_sel  <= '0;
                    end else if (!r_mv) begin
                        r_mv <= 1'b1;
                    end
                end
                ST_SIN_DATA: r_sel <= r_sel + 2'd1;
                ST_MOVE_MZ:  r_px  <= r_px - w_sh10[31:0];
                ST_MOVE_UPD: begin
                    r_pz <= r_pz - w_sh10[31:0];
                    r_mv <= 1'b1;
                end
                ST_VIEW: begin
                    r_view <= 1'b1;
                    r_sel  <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mx   <= i_s_tdata[9:0];
            r_my   <= i_s_tdata[18:10];
            r_keys <= i_s_tdata[22:19];
        end
        if (w_out_load)
            r_odata <= {7'b0, r_vz, r_sv[2], r_vx, r_pitch, r_yaw, r_pz, r_py, r_px};
        case (r_state)
            ST_TURN_P:   r_ynew <= w_turn_y;
            ST_MOVE_SEL: r_ang  <= w_move_ang;
            ST_VIEW:     r_ang  <= t_ang'({2'b0, r_yaw});
            ST_SIN_RED:  r_m    <= mod360(r_ang);
            ST_SIN_QUAD: begin
                if (r_m < 17'(ANG_90)) begin
                    r_q <= 2'd0;
                    r_r <= r_m[14:0];
                end else if (r_m < 17'(ANG_180)) begin
                    r_q <= 2'd1;
                    r_r <= 15'(r_m - 17'(ANG_90));
                end else if (r_m < 17'(ANG_270)) begin
                    r_q <= 2'd2;
                    r_r <= 15'(r_m - 17'(ANG_180));
                end else begin
                    r_q <= 2'd3;
                    r_r <= 15'(r_m - 17'(ANG_270));
                end
            end
            ST_SIN_DATA: begin
                r_sv[r_sel] <= w_sval;
                if (r_view && r_sel == 2'd1)
                    r_ang <= t_ang'(r_pitch);
                else
                    r_ang <= r_ang + ANG_90;
            end
            ST_VIEW_MZ:  r_vx <= w_neg14[15:0];
            ST_VIEW_VZ:  r_vz <= w_neg14[15:0];
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input accepted while a request is in progress");

    a_pitch_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TURN_FIX) |=> (r_pitch <= 16'sd23040 && r_pitch >= -16'sd23040))
        else $error("pitch out of range after turn");

    a_yaw_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TURN_FIX) |=> (r_yaw <= 17'd92160))
        else $error("yaw out of range after turn");

    a_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIN_ADDR) |-> (w_idx <= D14))
        else $error("sine index beyond table");

endmodule
